// ===== hw/rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg: box filter downsampler shared types and constants
// Request and result payload structs, register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   localparam int PIX_W          = 16;
   localparam int CFG_WIDTH_W    = 11;
   localparam int CFG_HEIGHT_W   = 13;
   localparam int SIZE_W         = 13;
   localparam int ROW_W          = 12;
   localparam int CMP_W          = 14;
   localparam int MAX_DST_HEIGHT = 4096;
   localparam int NUM_COMP       = 3;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CFG_WIDTH_W-1:0]  DST_WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HEIGHT_W-1:0] DST_HEIGHT_RESET = 13'd768;

   // register index, taken from paddr bit 2
   localparam logic REG_DST_WIDTH  = 1'b0;
   localparam logic REG_DST_HEIGHT = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] src_red;
      logic [PIX_W-1:0] src_green;
      logic [PIX_W-1:0] src_blue;
      logic             frame_start;
   } bfd_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] avg_red;
      logic [PIX_W-1:0] avg_green;
      logic [PIX_W-1:0] avg_blue;
      logic             row_end;
      logic             frame_end;
   } bfd_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/box_filter_downsample_top.sv =====
// Path: a request accepted at a clock edge passes through the accumulate stage
//   register and then the result queue before its result (if any) shows on rsp_valid.
// Throughput: one request per cycle while req_stall is low, set by the read-modify-write of the
//   column accumulator RAM (read at accept, written from the accumulate stage).
// Reset: sizes return to 1024 x 768, position counters and the result queue
//   clear; the column accumulator RAM is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// box_filter_downsample_top: FACTOR x FACTOR box filter decimator
// Sums each source block into a per-column accumulator line and emits the
// truncated block average on the block's last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_downsample_top
   import bfd_pkg::*;
#(
   parameter int FACTOR        = 2,
   parameter int MAX_DST_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire bfd_req_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bfd_rsp_type                rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int AREA      = FACTOR * FACTOR;
   localparam int AREA_W    = $clog2(AREA);
   localparam int SUM_W     = PIX_W + AREA_W;
   localparam int DIV_SHIFT = SUM_W + AREA_W;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL = ((64'd1 << DIV_SHIFT) + AREA - 1) / AREA;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int SUB_W     = (FACTOR > 1) ? $clog2(FACTOR) : 1;
   localparam int COL_W     = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
   localparam int LINE_W    = NUM_COMP * SUM_W;

   typedef logic [NUM_COMP-1:0][SUM_W-1:0] sums_type;

   typedef struct packed {
      sums_type sums;
      logic     row_end;
      logic     frame_end;
   } entry_type;

   // ---------------- configuration registers ----------------
   logic [CFG_WIDTH_W-1:0]  dst_width_ff;
   logic [CFG_HEIGHT_W-1:0] dst_height_ff;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_width_ff  <= DST_WIDTH_RESET;
         dst_height_ff <= DST_HEIGHT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_DST_WIDTH:  dst_width_ff  <= pwdata[CFG_WIDTH_W-1:0];
            REG_DST_HEIGHT: dst_height_ff <= pwdata[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DST_WIDTH:  prdata = CSR_DATA_W'(dst_width_ff);
         REG_DST_HEIGHT: prdata = CSR_DATA_W'(dst_height_ff);
         default:        prdata = '0;
      endcase
   end

   // effective sizes: zero acts as one, oversize is clamped
   logic [SIZE_W-1:0] eff_width;
   logic [SIZE_W-1:0] eff_height;

   always_comb begin
      if (dst_width_ff == '0) begin
         eff_width = SIZE_W'(1);
      end else if (SIZE_W'(dst_width_ff) > SIZE_W'(MAX_DST_WIDTH)) begin
         eff_width = SIZE_W'(MAX_DST_WIDTH);
      end else begin
         eff_width = SIZE_W'(dst_width_ff);
      end
      if (dst_height_ff == '0) begin
         eff_height = SIZE_W'(1);
      end else if (dst_height_ff > SIZE_W'(MAX_DST_HEIGHT)) begin
         eff_height = SIZE_W'(MAX_DST_HEIGHT);
      end else begin
         eff_height = dst_height_ff;
      end
   end

   // ---------------- position counters ----------------
   logic [SUB_W-1:0] sub_col_ff, sub_col_in;
   logic [SUB_W-1:0] sub_row_ff, sub_row_in;
   logic [COL_W-1:0] dest_col_ff, dest_col_in;
   logic [ROW_W-1:0] dest_row_ff, dest_row_in;

   logic             req_accept;
   logic [SUB_W-1:0] cur_sc, cur_sr;
   logic [COL_W-1:0] cur_dc;
   logic [ROW_W-1:0] cur_dr;
   logic [SUB_W:0]   sc_inc, sr_inc;
   logic             col_wrap, row_wrap;
   logic             last_col, last_row;
   logic             blk_first, blk_emit;
   logic [COL_W-1:0] col_sel;

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cur_sc = req_data.frame_start ? '0 : sub_col_ff;
      cur_sr = req_data.frame_start ? '0 : sub_row_ff;
      cur_dc = req_data.frame_start ? '0 : dest_col_ff;
      cur_dr = req_data.frame_start ? '0 : dest_row_ff;

      sc_inc   = {1'b0, cur_sc} + (SUB_W + 1)'(1);
      sr_inc   = {1'b0, cur_sr} + (SUB_W + 1)'(1);
      col_wrap = sc_inc >= (SUB_W + 1)'(FACTOR);
      row_wrap = sr_inc >= (SUB_W + 1)'(FACTOR);

      last_col = (CMP_W'(cur_dc) + CMP_W'(1)) >= CMP_W'(eff_width);
      last_row = (CMP_W'(cur_dr) + CMP_W'(1)) >= CMP_W'(eff_height);
      col_sel  = last_col ? COL_W'(eff_width - SIZE_W'(1)) : cur_dc;

      blk_first = (cur_sc == '0) && (cur_sr == '0);
      blk_emit  = col_wrap && row_wrap;

      sub_col_in  = cur_sc;
      sub_row_in  = cur_sr;
      dest_col_in = cur_dc;
      dest_row_in = cur_dr;
      if (col_wrap) begin
         sub_col_in = '0;
         if (last_col) begin
            dest_col_in = '0;
            if (row_wrap) begin
               sub_row_in  = '0;
               dest_row_in = last_row ? '0 : cur_dr + ROW_W'(1);
            end else begin
               sub_row_in = sr_inc[SUB_W-1:0];
            end
         end else begin
            dest_col_in = cur_dc + COL_W'(1);
         end
      end else begin
         sub_col_in = sc_inc[SUB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff  <= '0;
         sub_row_ff  <= '0;
         dest_col_ff <= '0;
         dest_row_ff <= '0;
      end else if (req_accept) begin
         sub_col_ff  <= sub_col_in;
         sub_row_ff  <= sub_row_in;
         dest_col_ff <= dest_col_in;
         dest_row_ff <= dest_row_in;
      end
   end

   // ---------------- accumulate stage ----------------
   logic                                 s1_valid_ff;
   logic                                 s1_first_ff;
   logic                                 s1_emit_ff;
   logic                                 s1_row_end_ff;
   logic                                 s1_frame_end_ff;
   logic [COL_W-1:0]                     s1_col_ff;
   logic [NUM_COMP-1:0][PIX_W-1:0]       s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_first_ff     <= blk_first;
         s1_emit_ff      <= blk_emit;
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
         s1_col_ff       <= col_sel;
         s1_pix_ff       <= {req_data.src_blue, req_data.src_green, req_data.src_red};
      end
   end

   sums_type         ram_rd_data;
   sums_type         new_sums;
   sums_type         base_sums;
   logic             fwd_valid_ff;
   logic [COL_W-1:0] fwd_col_ff;
   sums_type         fwd_sums_ff;

   bfd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_DST_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (new_sums),
      .rd_addr (col_sel),
      .rd_data (ram_rd_data)
   );

   // the RAM read misses the write made at the same edge; bypass it
   always_comb begin
      base_sums = (fwd_valid_ff && (fwd_col_ff == s1_col_ff)) ? fwd_sums_ff : ram_rd_data;
      for (int c = 0; c < NUM_COMP; c++) begin
         if (s1_first_ff) begin
            new_sums[c] = SUM_W'(s1_pix_ff[c]);
         end else begin
            new_sums[c] = base_sums[c] + SUM_W'(s1_pix_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_valid_ff;
      end
      fwd_col_ff  <= s1_col_ff;
      fwd_sums_ff <= new_sums;
   end

   // ---------------- result queue ----------------
   entry_type   queue_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;
   logic [2:0]  count_after;
   entry_type   head;
   logic [PROD_W-1:0] prod [NUM_COMP];
   logic [NUM_COMP-1:0][PIX_W-1:0] avg;

   assign push        = s1_valid_ff && s1_emit_ff;
   assign pop         = rsp_valid && !rsp_stall;
   assign count_after = 3'(count_ff) + 3'(push) - 3'(pop);
   // room must remain for the request being accepted, which pushes from the accumulate stage
   assign req_stall   = count_after >= 3'd2;
   assign rsp_valid   = count_ff != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_after[1:0];
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{sums:      new_sums,
                                  row_end:   s1_row_end_ff,
                                  frame_end: s1_frame_end_ff};
      end
   end

   // divide by the block area through a reciprocal multiply
   always_comb begin
      head = queue_ff[rd_ptr_ff];
      for (int c = 0; c < NUM_COMP; c++) begin
         prod[c] = PROD_W'(head.sums[c]) * PROD_W'(RECIP);
         avg[c]  = prod[c][DIV_SHIFT +: PIX_W];
      end
      rsp_data.avg_red   = avg[0];
      rsp_data.avg_green = avg[1];
      rsp_data.avg_blue  = avg[2];
      rsp_data.row_end   = head.row_end;
      rsp_data.frame_end = head.frame_end;
   end

   // ---------------- assertions ----------------
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |-> req_stall)
      else $error("request accepted with a full result queue");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_valid && !req_stall))
      else $error("accumulate stage holds a request that was never accepted");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> rsp_data.row_end)
      else $error("frame end without row end");

endmodule

`default_nettype wire

// ===== hw/rtl/bfd_ram.sv =====
// ----------------------------------------------------------------------------
// bfd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/bfd_average_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_average_checker: result checker for the box filter downsampler
// Watches the request, result and register channels, keeps its own copy of
// the block counters and column accumulator line, and compares every result
// against the oldest predicted block average.
// ----------------------------------------------------------------------------

module bfd_average_checker
   import bfd_pkg::*;
#(
   parameter int FACTOR        = 2,
   parameter int MAX_DST_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire bfd_req_type           req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire bfd_rsp_type           rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         mismatch_count,
   output int                         averages_checked,
   output int                         expected_left
);

   localparam int BLOCK_PIXELS = FACTOR * FACTOR;
   localparam int SUM_W        = PIX_W + $clog2(BLOCK_PIXELS) + 1;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } rgb_sum_type;

   rgb_sum_type              line_sums [MAX_DST_WIDTH];
   logic [CFG_WIDTH_W-1:0]   width_reg;
   logic [CFG_HEIGHT_W-1:0]  height_reg;
   int unsigned              sub_x, sub_y, out_x, out_y;
   bfd_rsp_type              pending_averages [$];

   task automatic fold_source_pixel(input bfd_req_type px);
      int unsigned w, h, col;
      logic        last_col, last_row;
      rgb_sum_type acc;
      bfd_rsp_type avg;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_DST_WIDTH) ? MAX_DST_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 :
          ((height_reg > MAX_DST_HEIGHT) ? MAX_DST_HEIGHT : height_reg);
      if (px.frame_start) begin
         sub_x = 0;
         sub_y = 0;
         out_x = 0;
         out_y = 0;
      end
      // a position past the last column or row counts as the last one
      last_col = (out_x + 1 >= w);
      last_row = (out_y + 1 >= h);
      col = last_col ? w - 1 : out_x;
      // top-left pixel of a block starts the accumulator fresh
      if (sub_x == 0 && sub_y == 0) acc = '0;
      else acc = line_sums[col];
      acc.red   = acc.red + px.src_red;
      acc.green = acc.green + px.src_green;
      acc.blue  = acc.blue + px.src_blue;
      line_sums[col] = acc;
      if (sub_x == FACTOR - 1 && sub_y == FACTOR - 1) begin
         avg.avg_red   = PIX_W'(acc.red / BLOCK_PIXELS);
         avg.avg_green = PIX_W'(acc.green / BLOCK_PIXELS);
         avg.avg_blue  = PIX_W'(acc.blue / BLOCK_PIXELS);
         avg.row_end   = last_col;
         avg.frame_end = last_col && last_row;
         pending_averages.push_back(avg);
      end
      sub_x++;
      if (sub_x == FACTOR) begin
         sub_x = 0;
         if (last_col) begin
            out_x = 0;
            sub_y++;
            if (sub_y == FACTOR) begin
               sub_y = 0;
               out_y = last_row ? 0 : out_y + 1;
            end
         end else begin
            out_x++;
         end
      end
   endtask

   task automatic check_average(input bfd_rsp_type got);
      bfd_rsp_type want;
      if (pending_averages.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: average with none pending: got %h %h %h row_end %b frame_end %b",
                     $time, got.avg_red, got.avg_green, got.avg_blue, got.row_end,
                     got.frame_end);
      end else begin
         want = pending_averages.pop_front();
         averages_checked++;
         if (got.avg_red !== want.avg_red || got.avg_green !== want.avg_green ||
             got.avg_blue !== want.avg_blue || got.row_end !== want.row_end ||
             got.frame_end !== want.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: average mismatch: expected %h %h %h row_end %b frame_end %b",
                        $time, want.avg_red, want.avg_green, want.avg_blue, want.row_end,
                        want.frame_end, "\n   got %h %h %h row_end %b frame_end %b",
                        got.avg_red, got.avg_green, got.avg_blue, got.row_end,
                        got.frame_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg        = DST_WIDTH_RESET;
         height_reg       = DST_HEIGHT_RESET;
         sub_x            = 0;
         sub_y            = 0;
         out_x            = 0;
         out_y            = 0;
         mismatch_count   = 0;
         averages_checked = 0;
         pending_averages.delete();
      end else begin
         // results first, so a request on the same edge cannot cover a stray one
         if (rsp_valid && !rsp_stall) check_average(rsp_data);
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_DST_WIDTH) width_reg = pwdata[CFG_WIDTH_W-1:0];
            else height_reg = pwdata[CFG_HEIGHT_W-1:0];
         end
         if (req_valid && !req_stall) fold_source_pixel(req_data);
      end
      expected_left <= pending_averages.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the box filter downsampler
// Drives source pixel streams over a range of destination sizes, with bursty
// requests and a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_top;
   import bfd_pkg::*;

   localparam int FACTOR           = 2;
   localparam int MAX_DST_WIDTH    = 1024;
   localparam int BLOCK_PIXELS     = FACTOR * FACTOR;
   localparam int CLK_PERIOD       = 10;
   localparam int TIMEOUT_CYCLES   = 500000;
   localparam int REQUEST_GOAL     = 1350;
   localparam int DRAIN_CYCLES     = 4;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum {PHASE_FRAMES, PHASE_SHRINK, PHASE_LARGE} phase_kind_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   bfd_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   bfd_rsp_type           rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count, averages_checked, expected_left;
   int requests_sent = 0;
   int size_settings = 0;
   int burst_left    = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int cur_width     = 1024;
   int cur_height    = 768;

   box_filter_downsample_top #(
      .FACTOR        (FACTOR),
      .MAX_DST_WIDTH (MAX_DST_WIDTH)
   ) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bfd_average_checker #(
      .FACTOR        (FACTOR),
      .MAX_DST_WIDTH (MAX_DST_WIDTH)
   ) u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .mismatch_count, .averages_checked, .expected_left
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int eff_size(input int raw, input int ceiling);
      return (raw == 0) ? 1 : ((raw > ceiling) ? ceiling : raw);
   endfunction

   function automatic logic [PIX_W-1:0] random_component();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic bfd_req_type make_pixel(input logic [PIX_W-1:0] r, g, b,
                                              input logic first);
      bfd_req_type px;
      px.src_red     = r;
      px.src_green   = g;
      px.src_blue    = b;
      px.frame_start = first;
      return px;
   endfunction

   function automatic bfd_req_type random_pixel(input logic first);
      return make_pixel(random_component(), random_component(), random_component(), first);
   endfunction

   // after each request: carry on the burst, or drop valid for a random gap
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_pixel(input bfd_req_type px);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      pace_sender();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
      // pixels that make no result may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // upper write data bits are junk the register must drop
   task automatic apply_sizes(input int w_raw, input int h_raw);
      wait_drained();
      write_csr({REG_DST_WIDTH, 2'b00}, ($urandom << CFG_WIDTH_W) | CSR_DATA_W'(w_raw));
      write_csr({REG_DST_HEIGHT, 2'b00}, ($urandom << CFG_HEIGHT_W) | CSR_DATA_W'(h_raw));
      cur_width  = eff_size(w_raw, MAX_DST_WIDTH);
      cur_height = eff_size(h_raw, MAX_DST_HEIGHT);
      size_settings++;
   endtask

   task automatic send_frames(input int frames);
      int total, stop, n, f;
      for (f = 0; f < frames; f++) begin
         total = BLOCK_PIXELS * cur_width * cur_height;
         stop  = total;
         // now and then cut a frame short
         if (total > 1 && $urandom_range(0, 7) == 0) stop = $urandom_range(1, total - 1);
         for (n = 0; n < stop; n++)
            send_pixel(random_pixel((n == 0 && (f == 0 || $urandom_range(0, 3) != 0)) ||
                                    $urandom_range(0, 99) == 0));
      end
   endtask

   initial begin : stimulus
      phase_kind_type kind;
      int             i, count, new_w, new_h;
      int             large_left;
      large_left = 2;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      apply_sizes(1, 1);
      for (i = 0; i < BLOCK_PIXELS; i++) send_pixel(make_pixel('1, '1, '1, i == 0));
      // next frame reached through the frame-end wrap, no frame start
      for (i = 0; i < BLOCK_PIXELS; i++) send_pixel(make_pixel('0, '0, '0, 1'b0));
      // one count short of a full block sum, so the average truncates down
      for (i = 0; i < BLOCK_PIXELS; i++)
         send_pixel(make_pixel((i == BLOCK_PIXELS - 1) ? 16'd0 : 16'd1, 16'd3,
                               (i == BLOCK_PIXELS - 1) ? 16'hFFFE : 16'hFFFF, i == 0));
      // frame start partway through a block
      send_pixel(make_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b1));
      send_pixel(random_pixel(1'b0));
      for (i = 0; i < BLOCK_PIXELS; i++) send_pixel(random_pixel(i == 0));
      apply_sizes(0, 0);
      for (i = 0; i < BLOCK_PIXELS; i++) send_pixel(random_pixel(i == 0));
      apply_sizes(2047, 8191);
      for (i = 0; i < 3; i++) send_pixel(random_pixel(i == 0));

      // first random frame runs under a long receiver hold-off
      apply_sizes(8, 4);
      hold_asked++;
      send_frames(1);

      while (requests_sent < REQUEST_GOAL) begin
         case ($urandom_range(0, 9))
            0: kind = PHASE_SHRINK;
            1: kind = (large_left > 0) ? PHASE_LARGE : PHASE_FRAMES;
            default: kind = PHASE_FRAMES;
         endcase
         case (kind)
            PHASE_SHRINK: begin
               count = $urandom_range(1, 60);
               for (i = 0; i < count; i++) send_pixel(random_pixel(i == 0));
               // only narrow mid-frame, so no column is read before it is written
               apply_sizes($urandom_range(1, (cur_width < 8) ? cur_width : 8),
                           $urandom_range(0, 6));
               count = $urandom_range(20, 120);
               for (i = 0; i < count; i++) send_pixel(random_pixel($urandom_range(0, 99) == 0));
            end
            PHASE_LARGE: begin
               large_left--;
               apply_sizes($urandom_range(0, 1) ? 2047 : MAX_DST_WIDTH,
                           $urandom_range(0, 1) ? 8191 : MAX_DST_HEIGHT);
               count = $urandom_range(20, 50);
               for (i = 0; i < count; i++) send_pixel(random_pixel(i == 0));
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: new_w = 0;
                  1: new_w = $urandom_range(9, 24);
                  default: new_w = $urandom_range(1, 8);
               endcase
               new_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
               apply_sizes(new_w, new_h);
               if ($urandom_range(0, 5) == 0) hold_asked++;
               send_frames((new_w > 8) ? 1 : $urandom_range(1, 3));
            end
         endcase
      end

      wait_drained();
      $display("ran %0d requests over %0d size settings, %0d averages compared",
               requests_sent, size_settings, averages_checked);
      $display("incl. saturated and zero blocks, truncation, restarts, odd and narrowed sizes");
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("box_filter_downsample_top regression: pass");
      end else begin
         $display("box_filter_downsample_top regression: fail");
      end
      $finish;
   end

   initial begin : rsp_stall_pattern
      int stretch, pct;
      @(posedge clock);
      forever begin
         if (hold_asked != hold_served) begin
            // long hold-off so the block backs up into its input
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else begin
            case ($urandom_range(0, 3))
               0: pct = 0;
               1: pct = 25;
               2: pct = 60;
               default: pct = 90;
            endcase
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
               rsp_stall <= ($urandom_range(0, 99) < pct);
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("box_filter_downsample_top regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_ram.sv
hw/rtl/box_filter_downsample_top.sv
test/bfd_average_checker.sv
test/tb_top.sv
